// ===== design/tlw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tlw_pkg;

    localparam int COORD_BITS = 10;
    localparam int WIN_BITS   = 11;
    localparam int COUNT_BITS = 14;
    localparam int COLOR_BITS = 16;
    localparam int BRUSH_BITS = 4;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int PROD_BITS  = BRUSH_BITS + COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * BRUSH_BITS;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [WIN_BITS-1:0]   win_t;
    typedef logic [BRUSH_BITS-1:0] brush_t;
    typedef logic [COLOR_BITS-1:0] color_t;

    typedef struct packed {
        cmd_t   cmd;
        coord_t x_begin;
        coord_t y_begin;
        coord_t x_finish;
        coord_t y_finish;
        brush_t brush_width;
        color_t color_in;
    } item_t;

    typedef struct packed {
        win_t                  win_x_start;
        win_t                  win_y_start;
        win_t                  win_x_end;
        win_t                  win_y_end;
        logic [COUNT_BITS-1:0] pixel_count;
        color_t                pixel_color;
        logic                  last;
    } result_t;

endpackage

`default_nettype wire

// ===== design/tlw_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlw_in_reg
    import tlw_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    input  wire logic  advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg, valid_next;
    item_t item_reg;

    // The register frees up in the same cycle its item moves on.
    assign in_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== design/tlw_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlw_core
    import tlw_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  fire,
    input  wire item_t item,
    output logic       res_valid,
    output result_t    res
);

    logic                       active_reg, active_next;
    coord_t                     cur_x_reg, cur_x_next;
    coord_t                     cur_y_reg, cur_y_next;
    coord_t                     end_major_reg, end_major_next;
    logic signed [ERR_BITS-1:0] err_reg, err_next;
    coord_t                     dmaj_reg, dmaj_next;
    coord_t                     dmin_reg, dmin_next;
    logic                       neg_reg, neg_next;
    logic                       steep_reg, steep_next;
    brush_t                     brush_reg, brush_next;
    color_t                     color_reg, color_next;

    logic                       is_start;
    brush_t                     w_start;
    coord_t                     adx, ady, span;
    logic                       vert, horiz;
    logic [PROD_BITS-1:0]       str_count;
    logic                       s_steep, s_swap, s_neg;
    coord_t                     px0, py0, px1, py1, s_end, s_dmaj, s_dmin;
    logic signed [ERR_BITS-1:0] s_err;

    coord_t                     p_x, p_y, p_end, p_dmaj, p_dmin, p_major;
    logic signed [ERR_BITS-1:0] p_err, n_err;
    logic                       p_neg, p_steep, p_last;
    brush_t                     p_w;
    color_t                     p_color;
    coord_t                     n_x, n_y;
    logic [SQ_BITS-1:0]         p_sq;
    result_t                    pt_res, str_res;

    assign is_start = (item.cmd == CMD_START);

    // Line setup from a start item.
    always_comb begin
        w_start = (item.brush_width == '0) ? brush_t'(1) : item.brush_width;
        adx = (item.x_finish > item.x_begin) ? item.x_finish - item.x_begin
                                             : item.x_begin - item.x_finish;
        ady = (item.y_finish > item.y_begin) ? item.y_finish - item.y_begin
                                             : item.y_begin - item.y_finish;
        vert  = (item.x_begin == item.x_finish);
        horiz = (item.y_begin == item.y_finish);
        span  = vert ? ady : adx;
        str_count = PROD_BITS'(w_start) * (PROD_BITS'(span) + PROD_BITS'(1));

        s_steep = !(ady < adx);
        s_swap  = s_steep ? (item.y_begin > item.y_finish)
                          : (item.x_begin > item.x_finish);
        px0 = s_swap ? item.x_finish : item.x_begin;
        py0 = s_swap ? item.y_finish : item.y_begin;
        px1 = s_swap ? item.x_begin  : item.x_finish;
        py1 = s_swap ? item.y_begin  : item.y_finish;
        s_neg  = s_steep ? (px1 < px0) : (py1 < py0);
        s_end  = s_steep ? py1 : px1;
        s_dmaj = s_steep ? ady : adx;
        s_dmin = s_steep ? adx : ady;
        s_err  = $signed({1'b0, s_dmin, 1'b0}) - $signed({2'b00, s_dmaj});

        str_res.win_x_start = vert ? WIN_BITS'(item.x_begin)
                                   : WIN_BITS'(vert || item.x_begin < item.x_finish
                                               ? item.x_begin : item.x_finish);
        str_res.win_y_start = vert ? WIN_BITS'(item.y_begin < item.y_finish
                                               ? item.y_begin : item.y_finish)
                                   : WIN_BITS'(item.y_begin);
        str_res.win_x_end   = vert ? WIN_BITS'(item.x_begin) + WIN_BITS'(w_start)
                                     - WIN_BITS'(1)
                                   : WIN_BITS'(item.x_begin < item.x_finish
                                               ? item.x_finish : item.x_begin);
        str_res.win_y_end   = vert ? WIN_BITS'(item.y_begin < item.y_finish
                                               ? item.y_finish : item.y_begin)
                                   : WIN_BITS'(item.y_begin) + WIN_BITS'(w_start)
                                     - WIN_BITS'(1);
        str_res.pixel_count = COUNT_BITS'(str_count);
        str_res.pixel_color = item.color_in;
        str_res.last        = 1'b1;
    end

    // Current point: the fresh setup on a start, the stored walk on a step.
    always_comb begin
        p_x     = is_start ? px0     : cur_x_reg;
        p_y     = is_start ? py0     : cur_y_reg;
        p_end   = is_start ? s_end   : end_major_reg;
        p_err   = is_start ? s_err   : err_reg;
        p_dmaj  = is_start ? s_dmaj  : dmaj_reg;
        p_dmin  = is_start ? s_dmin  : dmin_reg;
        p_neg   = is_start ? s_neg   : neg_reg;
        p_steep = is_start ? s_steep : steep_reg;
        p_w     = is_start ? w_start : brush_reg;
        p_color = is_start ? item.color_in : color_reg;

        p_major = p_steep ? p_y : p_x;
        p_last  = (p_major >= p_end);

        n_x   = p_x;
        n_y   = p_y;
        n_err = p_err + $signed({1'b0, p_dmin, 1'b0});
        if (p_err > 0) begin
            if (p_steep) begin
                n_x = p_neg ? p_x - coord_t'(1) : p_x + coord_t'(1);
            end else begin
                n_y = p_neg ? p_y - coord_t'(1) : p_y + coord_t'(1);
            end
            n_err = n_err - $signed({1'b0, p_dmaj, 1'b0});
        end
        if (p_steep) begin
            n_y = n_y + coord_t'(1);
        end else begin
            n_x = n_x + coord_t'(1);
        end

        p_sq = SQ_BITS'(p_w) * SQ_BITS'(p_w);
        pt_res.win_x_start = WIN_BITS'(p_x);
        pt_res.win_y_start = WIN_BITS'(p_y);
        pt_res.win_x_end   = WIN_BITS'(p_x) + WIN_BITS'(p_w) - WIN_BITS'(1);
        pt_res.win_y_end   = WIN_BITS'(p_y) + WIN_BITS'(p_w) - WIN_BITS'(1);
        pt_res.pixel_count = COUNT_BITS'(p_sq);
        pt_res.pixel_color = p_color;
        pt_res.last        = p_last;
    end

    always_comb begin
        active_next    = active_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        end_major_next = end_major_reg;
        err_next       = err_reg;
        dmaj_next      = dmaj_reg;
        dmin_next      = dmin_reg;
        neg_next       = neg_reg;
        steep_next     = steep_reg;
        brush_next     = brush_reg;
        color_next     = color_reg;
        res_valid      = 1'b0;
        res            = pt_res;

        if (fire) begin
            if (is_start) begin
                brush_next  = w_start;
                color_next  = item.color_in;
                active_next = 1'b0;
                res_valid   = 1'b1;
                if (vert || horiz) begin
                    res = str_res;
                end else begin
                    // The walk's first point is never the end point, so the
                    // stored state is always the advanced one.
                    active_next    = !p_last;
                    cur_x_next     = n_x;
                    cur_y_next     = n_y;
                    err_next       = n_err;
                    end_major_next = s_end;
                    dmaj_next      = s_dmaj;
                    dmin_next      = s_dmin;
                    neg_next       = s_neg;
                    steep_next     = s_steep;
                end
            end else if (active_reg) begin
                res_valid = 1'b1;
                if (p_last) begin
                    active_next = 1'b0;
                end else begin
                    cur_x_next = n_x;
                    cur_y_next = n_y;
                    err_next   = n_err;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            end_major_reg <= '0;
            err_reg       <= '0;
            dmaj_reg      <= '0;
            dmin_reg      <= '0;
            neg_reg       <= 1'b0;
            steep_reg     <= 1'b0;
            brush_reg     <= brush_t'(1);
            color_reg     <= '0;
        end else begin
            active_reg    <= active_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            end_major_reg <= end_major_next;
            err_reg       <= err_next;
            dmaj_reg      <= dmaj_next;
            dmin_reg      <= dmin_next;
            neg_reg       <= neg_next;
            steep_reg     <= steep_next;
            brush_reg     <= brush_next;
            color_reg     <= color_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/tlw_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlw_out_reg
    import tlw_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire result_t load_res,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= load_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

// ===== design/thick_line_window_generator_unit.sv =====
// An accepted item is held in the input register; its result, if any, is loaded into the
// output register and presented on the m_ side. Throughput: one item per cycle, set by the
// combinational Bresenham step in tlw_core, while the output register is empty or draining.
// Items that produce no result (a step with no line active) still leave the input register.
// Reset: synchronous, active low on aresetn; both channels come out empty, no line
// is active, the brush is one pixel and the stored color is zero.
`timescale 1ns / 1ps
`default_nettype none

module thick_line_window_generator_unit
    import tlw_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_cmd,
    input  wire logic [COORD_BITS-1:0] s_x_begin,
    input  wire logic [COORD_BITS-1:0] s_y_begin,
    input  wire logic [COORD_BITS-1:0] s_x_finish,
    input  wire logic [COORD_BITS-1:0] s_y_finish,
    input  wire logic [BRUSH_BITS-1:0] s_brush_width,
    input  wire logic [COLOR_BITS-1:0] s_color_in,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [WIN_BITS-1:0]        m_win_x_start,
    output logic [WIN_BITS-1:0]        m_win_y_start,
    output logic [WIN_BITS-1:0]        m_win_x_end,
    output logic [WIN_BITS-1:0]        m_win_y_end,
    output logic [COUNT_BITS-1:0]      m_pixel_count,
    output logic [COLOR_BITS-1:0]      m_pixel_color,
    output logic                       m_last
);

    // The input side lands in a one-entry input register, so a new transfer can
    // be taken while a finished result is still held in the output register.
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_item.cmd         = cmd_t'(s_cmd);
    assign in_item.x_begin     = s_x_begin;
    assign in_item.y_begin     = s_y_begin;
    assign in_item.x_finish    = s_x_finish;
    assign in_item.y_finish    = s_y_finish;
    assign in_item.brush_width = s_brush_width;
    assign in_item.color_in    = s_color_in;

    // The held item is processed whenever the output register is empty or is
    // being drained in this cycle. Every held item advances, whether it makes
    // a result or not; only items that make a result are loaded downstream.
    assign advance = item_valid && (!m_valid || m_ready);

    tlw_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Line state and the combinational step: setup on a start, one Bresenham
    // point per step, straight lines answered with a single full window.
    tlw_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    tlw_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && res_valid),
        .load_res  (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_win_x_start = out_res.win_x_start;
    assign m_win_y_start = out_res.win_y_start;
    assign m_win_x_end   = out_res.win_x_end;
    assign m_win_y_end   = out_res.win_y_end;
    assign m_pixel_count = out_res.pixel_count;
    assign m_pixel_color = out_res.pixel_color;
    assign m_last        = out_res.last;

endmodule

`default_nettype wire

// ===== design/tlw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlw_checker
    import tlw_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  s_cmd,
    input wire logic [COORD_BITS-1:0] s_x_begin,
    input wire logic [COORD_BITS-1:0] s_y_begin,
    input wire logic [COORD_BITS-1:0] s_x_finish,
    input wire logic [COORD_BITS-1:0] s_y_finish,
    input wire logic [BRUSH_BITS-1:0] s_brush_width,
    input wire logic [COLOR_BITS-1:0] s_color_in,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [WIN_BITS-1:0]   m_win_x_start,
    input wire logic [WIN_BITS-1:0]   m_win_y_start,
    input wire logic [WIN_BITS-1:0]   m_win_x_end,
    input wire logic [WIN_BITS-1:0]   m_win_y_end,
    input wire logic [COUNT_BITS-1:0] m_pixel_count,
    input wire logic [COLOR_BITS-1:0] m_pixel_color,
    input wire logic                  m_last
);

    // The result channel is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds until its transfer.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_win_x_start)
            && $stable(m_win_y_start) && $stable(m_win_x_end)
            && $stable(m_win_y_end) && $stable(m_pixel_count)
            && $stable(m_pixel_color) && $stable(m_last))
        else $error("stalled result changed");

    // Every window is well ordered and covers at least one pixel.
    a_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_win_x_end >= m_win_x_start && m_win_y_end >= m_win_y_start
            && m_pixel_count != '0)
        else $error("malformed window");

    // Windows before the end of a line are square brush windows.
    a_square: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |->
            (m_win_x_end - m_win_x_start) == (m_win_y_end - m_win_y_start))
        else $error("non-square intermediate window");

endmodule

bind thick_line_window_generator_unit tlw_checker u_tlw_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_thick_line_window_generator_unit.sv =====
`timescale 1ns / 1ps

module tb_thick_line_window_generator_unit;
    import tlw_pkg::*;

    // The limit sits well above the slowest correct run, even with
    // every transfer delayed by the longest idle bursts on both sides.
    localparam int CYCLE_LIMIT = 400000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;

    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_cmd = CMD_START;
    logic [COORD_BITS-1:0] s_x_begin = '0;
    logic [COORD_BITS-1:0] s_y_begin = '0;
    logic [COORD_BITS-1:0] s_x_finish = '0;
    logic [COORD_BITS-1:0] s_y_finish = '0;
    logic [BRUSH_BITS-1:0] s_brush_width = '0;
    logic [COLOR_BITS-1:0] s_color_in = '0;

    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [WIN_BITS-1:0]   m_win_x_start;
    logic [WIN_BITS-1:0]   m_win_y_start;
    logic [WIN_BITS-1:0]   m_win_x_end;
    logic [WIN_BITS-1:0]   m_win_y_end;
    logic [COUNT_BITS-1:0] m_pixel_count;
    logic [COLOR_BITS-1:0] m_pixel_color;
    logic                  m_last;

    thick_line_window_generator_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_x_begin     (s_x_begin),
        .s_y_begin     (s_y_begin),
        .s_x_finish    (s_x_finish),
        .s_y_finish    (s_y_finish),
        .s_brush_width (s_brush_width),
        .s_color_in    (s_color_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_win_x_start (m_win_x_start),
        .m_win_y_start (m_win_y_start),
        .m_win_x_end   (m_win_x_end),
        .m_win_y_end   (m_win_y_end),
        .m_pixel_count (m_pixel_count),
        .m_pixel_color (m_pixel_color),
        .m_last        (m_last)
    );

    // Windows that the line tracer has predicted and the block has not yet
    // delivered, oldest first.
    result_t expected_windows[$];
    int      windows_predicted = 0;
    int      error_count = 0;
    int      cycle_count = 0;

    // Chance in percent that either side starts an idle burst at a given point.
    // Zero turns idling off on both sides.
    int      idle_odds = 0;

    // Private copy of the line walker's state; coordinates are kept at the block's width.
    logic    line_on = 1'b0;
    coord_t  pos_x = '0;
    coord_t  pos_y = '0;
    coord_t  major_stop = '0;
    int      err_acc = 0;
    int      run_major = 0;
    int      run_minor = 0;
    logic    minor_down = 1'b0;
    logic    y_major = 1'b0;
    int      brush_w = 1;
    color_t  line_rgb = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // A hung handshake must not keep the run alive forever.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Emits the brush window at the current point and then takes one Bresenham
    // step along the major axis, moving the minor coordinate when the error
    // term has gone positive. The window at the end point closes the line.
    task automatic plot_brush();
        result_t win;
        coord_t  major_pos;
        major_pos = y_major ? pos_y : pos_x;
        win.win_x_start = WIN_BITS'(pos_x);
        win.win_y_start = WIN_BITS'(pos_y);
        win.win_x_end   = WIN_BITS'(int'(pos_x) + brush_w - 1);
        win.win_y_end   = WIN_BITS'(int'(pos_y) + brush_w - 1);
        win.pixel_count = COUNT_BITS'(brush_w * brush_w);
        win.pixel_color = line_rgb;
        win.last        = (major_pos >= major_stop);
        expected_windows.push_back(win);
        windows_predicted++;
        if (win.last) begin
            line_on = 1'b0;
            return;
        end
        if (err_acc > 0) begin
            if (y_major)
                pos_x = minor_down ? pos_x - 1'b1 : pos_x + 1'b1;
            else
                pos_y = minor_down ? pos_y - 1'b1 : pos_y + 1'b1;
            err_acc -= 2 * run_major;
        end
        err_acc += 2 * run_minor;
        if (y_major)
            pos_y = pos_y + 1'b1;
        else
            pos_x = pos_x + 1'b1;
    endtask

    // Predicts the window, if any, caused by one accepted input transfer.
    // A start loads a new line and drops any old one; straight lines and
    // single points are answered by one window that covers them whole.
    task automatic trace_line_item(input cmd_t op, input coord_t xb, input coord_t yb,
                                   input coord_t xf, input coord_t yf,
                                   input brush_t bw, input color_t rgb);
        result_t win;
        coord_t  ax, ay, bx, by, tmp;
        int      span_x, span_y;
        if (op == CMD_STEP) begin
            // A step with no line in progress is silently absorbed.
            if (line_on)
                plot_brush();
            return;
        end
        brush_w  = (bw == '0) ? 1 : int'(bw);
        line_rgb = rgb;
        line_on  = 1'b0;
        ax = xb;
        ay = yb;
        bx = xf;
        by = yf;
        span_x = (bx > ax) ? int'(bx) - int'(ax) : int'(ax) - int'(bx);
        span_y = (by > ay) ? int'(by) - int'(ay) : int'(ay) - int'(by);
        win.pixel_color = rgb;
        win.last        = 1'b1;
        if (ax == bx) begin
            // Vertical line; equal endpoints land here as a span of zero.
            win.win_x_start = WIN_BITS'(ax);
            win.win_y_start = WIN_BITS'((ay < by) ? ay : by);
            win.win_x_end   = WIN_BITS'(int'(ax) + brush_w - 1);
            win.win_y_end   = WIN_BITS'((ay < by) ? by : ay);
            win.pixel_count = COUNT_BITS'(brush_w * (span_y + 1));
            expected_windows.push_back(win);
            windows_predicted++;
            return;
        end
        if (ay == by) begin
            win.win_x_start = WIN_BITS'((ax < bx) ? ax : bx);
            win.win_y_start = WIN_BITS'(ay);
            win.win_x_end   = WIN_BITS'((ax < bx) ? bx : ax);
            win.win_y_end   = WIN_BITS'(int'(ay) + brush_w - 1);
            win.pixel_count = COUNT_BITS'(brush_w * (span_x + 1));
            expected_windows.push_back(win);
            windows_predicted++;
            return;
        end
        // Order the endpoints so the major coordinate increases. A diagonal
        // with equal spans is walked with y as the major axis.
        if (span_y < span_x) begin
            y_major = 1'b0;
            if (ax > bx) begin
                tmp = ax; ax = bx; bx = tmp;
                tmp = ay; ay = by; by = tmp;
            end
            run_major  = span_x;
            run_minor  = span_y;
            minor_down = (by < ay);
            major_stop = bx;
        end else begin
            y_major = 1'b1;
            if (ay > by) begin
                tmp = ax; ax = bx; bx = tmp;
                tmp = ay; ay = by; by = tmp;
            end
            run_major  = span_y;
            run_minor  = span_x;
            minor_down = (bx < ax);
            major_stop = by;
        end
        pos_x   = ax;
        pos_y   = ay;
        err_acc = 2 * run_minor - run_major;
        line_on = 1'b1;
        plot_brush();
    endtask

    // Presents one item on the input channel and holds it until the transfer
    // happens. Valid is left high afterwards, so back-to-back items keep it
    // high without a glitch; an idle burst or the end of the run lowers it.
    task automatic send_item(input cmd_t op, input coord_t xb, input coord_t yb,
                             input coord_t xf, input coord_t yf,
                             input brush_t bw, input color_t rgb);
        int gap;
        if (idle_odds > 0 && $urandom_range(1, 100) <= idle_odds) begin
            gap = $urandom_range(1, 10);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end else begin
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= op;
        s_x_begin     <= xb;
        s_y_begin     <= yb;
        s_x_finish    <= xf;
        s_y_finish    <= yf;
        s_brush_width <= bw;
        s_color_in    <= rgb;
        do
            @(posedge aclk);
        while (!s_ready);
        trace_line_item(op, xb, yb, xf, yf, bw, rgb);
    endtask

    // A step carries random junk in the start-only fields, which must be ignored.
    task automatic send_step();
        send_item(CMD_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), brush_t'($urandom), color_t'($urandom));
    endtask

    // The receiving side stalls in random bursts while idling is enabled.
    always begin
        @(negedge aclk);
        if (aresetn && idle_odds > 0 && $urandom_range(1, 100) <= idle_odds) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        m_ready <= 1'b1;
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Every result transfer is compared against the oldest predicted window.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_windows.size() == 0) begin
                error_count++;
                $error("Result transfer arrived with no window expected.");
            end else begin
                want = expected_windows.pop_front();
                check_field("win_x_start", want.win_x_start, m_win_x_start);
                check_field("win_y_start", want.win_y_start, m_win_y_start);
                check_field("win_x_end", want.win_x_end, m_win_x_end);
                check_field("win_y_end", want.win_y_end, m_win_y_end);
                check_field("pixel_count", want.pixel_count, m_pixel_count);
                check_field("pixel_color", want.pixel_color, m_pixel_color);
                check_field("last", want.last, m_last);
            end
        end
    end

    // Steps that arrive before any line has been started produce nothing.
    task automatic test_step_without_line();
        send_step();
    endtask

    // Straight lines at the coordinate and brush extremes, in both directions,
    // plus a single point drawn with a zero brush that must act as one pixel.
    task automatic test_straight_lines();
        send_item(CMD_START, 10'd0, 10'd0, 10'd0, 10'd1023, 4'd15, 16'hFFFF);
        send_item(CMD_START, 10'd1023, 10'd1023, 10'd1023, 10'd0, 4'd1, 16'h0000);
        send_item(CMD_START, 10'd1023, 10'd1023, 10'd0, 10'd1023, 4'd15, 16'hA5A5);
        send_item(CMD_START, 10'd512, 10'd512, 10'd512, 10'd512, 4'd0, 16'h5A5A);
    endtask

    // Short walked lines: a shallow one followed by a step after its end, a
    // steep one whose minor coordinate falls, and an equal-span diagonal.
    task automatic test_bresenham_walks();
        send_item(CMD_START, 10'd0, 10'd0, 10'd4, 10'd1, 4'd2, 16'h1234);
        repeat (5) send_step();
        send_item(CMD_START, 10'd7, 10'd8, 10'd10, 10'd2, 4'd15, 16'hF00F);
        repeat (6) send_step();
        send_item(CMD_START, 10'd1023, 10'd0, 10'd1020, 10'd3, 4'd8, 16'h0FF0);
        repeat (3) send_step();
    endtask

    // A new start in the middle of a long line abandons the old one.
    task automatic test_restart_midline();
        send_item(CMD_START, 10'd0, 10'd1023, 10'd1023, 10'd0, 4'd4, 16'hBEEF);
        send_step();
        send_item(CMD_START, 10'd100, 10'd200, 10'd97, 10'd199, 4'd3, 16'hCAFE);
        repeat (3) send_step();
    endtask

    function automatic coord_t near_coord(input coord_t base, input int reach);
        int pos;
        pos = int'(base) + $urandom_range(0, 2 * reach) - reach;
        if (pos < 0)
            pos = 0;
        if (pos > 1023)
            pos = 1023;
        return coord_t'(pos);
    endfunction

    // Mostly complete lines with random content: a start followed by steps
    // until the end point. Some lines are cut short by the next start and
    // some finished lines get stray steps. Most lines are short so that many
    // of them fit in the run; a few span the whole coordinate range.
    task automatic test_random_lines(input int window_goal);
        int     goal_mark, shape;
        coord_t xb, yb, xf, yf;
        goal_mark = windows_predicted + window_goal;
        while (windows_predicted < goal_mark) begin
            shape = $urandom_range(0, 99);
            xb = coord_t'($urandom);
            yb = coord_t'($urandom);
            xf = near_coord(xb, 24);
            yf = near_coord(yb, 24);
            if (shape < 8)
                xf = xb;
            else if (shape < 16)
                yf = yb;
            else if (shape < 19) begin
                xf = xb;
                yf = yb;
            end else if (shape < 21) begin
                xf = coord_t'($urandom);
                yf = coord_t'($urandom);
            end
            send_item(CMD_START, xb, yb, xf, yf, brush_t'($urandom_range(0, 15)),
                      color_t'($urandom));
            while (line_on && $urandom_range(0, 39) != 0)
                send_step();
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_step();
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        idle_odds = 30;
        test_step_without_line();
        test_straight_lines();
        test_bresenham_walks();
        test_restart_midline();

        // Random traffic under changing amounts of idling, ending with a
        // stretch at full rate on both sides.
        idle_odds = 25;
        test_random_lines(500);
        idle_odds = 0;
        test_random_lines(200);
        idle_odds = 60;
        test_random_lines(400);
        idle_odds = 10;
        test_random_lines(500);
        idle_odds = 0;
        test_random_lines(400);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_windows.size() != 0)
            @(posedge aclk);
        // Give a stray late result the chance to show up before the verdict.
        repeat (16) @(posedge aclk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
